// ===== hw/rtl/sha512_pkg.sv =====
`default_nettype none
package sha512_pkg;

    // one queued transaction from the front to the back
    typedef struct packed {
        logic [63:0] word;
        logic        start;
        logic        last;
        logic [3:0]  nbytes;
    } t_item;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] v;
        unique case (idx)
            3'd0: v = 64'h6A09E667F3BCC908;
            3'd1: v = 64'hBB67AE8584CAA73B;
            3'd2: v = 64'h3C6EF372FE94F82B;
            3'd3: v = 64'hA54FF53A5F1D36F1;
            3'd4: v = 64'h510E527FADE682D1;
            3'd5: v = 64'h9B05688C2B3E6C1F;
            3'd6: v = 64'h1F83D9ABFB41BD6B;
            default: v = 64'h5BE0CD19137E2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] j);
        logic [63:0] k [0:79];
        k = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
        return k[j];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha512_queue.sv =====
`default_nettype none
// two-entry queue between the word front end and the compression engine
module sha512_queue
    import sha512_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);
    t_item      r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/sha512_core.sv =====
`default_nettype none
// back end: block assembly, padding, 80-round compression, digest output
module sha512_core
    import sha512_pkg::*;
#(
    parameter int ROUNDS = 80
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    localparam logic [2:0] S_IN = 3'd0, S_PAD = 3'd1, S_CMP = 3'd2, S_FIN = 3'd3,
                           S_OUT = 3'd4;

    logic [2:0]  r_state;
    logic [63:0] r_h [0:7];
    logic [63:0] r_v [0:7];
    logic [63:0] r_w [0:15];
    logic [3:0]  r_pos;
    logic [6:0]  r_rnd;
    logic [63:0] r_bytes;
    logic        r_padding;  // final word taken, padding in progress
    logic        r_lenblk;   // pad byte already placed, only zero fill and length left
    logic [2:0]  r_oidx;
    logic        r_lastlen;  // length high word placed in the current block

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // word accepted from the queue, with final-word masking and pad byte
    logic [3:0]  vb;
    logic [63:0] keep, padw, in_word;
    logic [63:0] bytes_base, bytes_new;
    always_comb begin
        vb = (i_item.nbytes > 4'd8) ? 4'd8 : i_item.nbytes;
        keep = (vb == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {vb[3:0], 3'b000});
        padw = (vb == 4'd8) ? 64'd0 : (PAD_WORD >> {vb, 3'b000});
        in_word = i_item.last ? ((i_item.word & keep) | padw) : i_item.word;
        bytes_base = i_item.start ? 64'd0 : r_bytes;
        bytes_new = bytes_base + (i_item.last ? {60'd0, vb} : 64'd8);
    end

    // schedule and round datapath
    logic [6:0]  rnd;
    logic [63:0] w2, w15, s0, s1, wt, t1, t2, e, a;
    always_comb begin
        rnd = r_rnd;
        w2  = r_w[4'(rnd - 7'd2)];
        w15 = r_w[4'(rnd - 7'd15)];
        s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
        s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
        wt  = (rnd < 7'd16) ? r_w[rnd[3:0]]
              : s1 + r_w[4'(rnd - 7'd7)] + s0 + r_w[rnd[3:0]];
        e   = r_v[4];
        a   = r_v[0];
        t1  = r_v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(rnd) + wt;
        t2  = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_pop         = (r_state == S_IN) && i_valid;
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN; r_pos <= 4'd0; r_rnd <= 7'd0; r_bytes <= 64'd0;
            r_padding <= 1'b0; r_lenblk <= 1'b0; r_oidx <= 3'd0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            unique case (r_state)
                S_IN: if (i_valid) begin
                    logic [3:0] p;
                    p = i_item.start ? 4'd0 : r_pos;
                    if (i_item.start)
                        for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                    r_bytes <= bytes_new;
                    r_w[p] <= in_word;
                    r_pos <= p + 4'd1;
                    if (i_item.last) begin
                        r_padding <= 1'b1;
                        if (vb == 4'd8) begin
                            // explicit pad word still to come
                            r_lenblk <= 1'b0;
                            r_state <= S_PAD;
                            if (p == 4'd15) begin
                                r_state <= S_CMP; r_rnd <= 7'd0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end
                        end else begin
                            r_lenblk <= 1'b1;
                            r_state <= S_PAD;
                            // pad byte landed in the last slot: block is full
                            if (p == 4'd15) begin
                                r_state <= S_CMP; r_rnd <= 7'd0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end
                        end
                    end else if (p == 4'd15) begin
                        r_state <= S_CMP; r_rnd <= 7'd0; r_padding <= 1'b0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                S_PAD: begin
                    // r_lenblk low: pad word pending; high: zero fill, length in 14 and 15
                    logic [63:0] pw;
                    if (!r_lenblk) begin
                        pw = PAD_WORD;
                        r_lenblk <= 1'b1;
                    end else if (r_pos == 4'd14)
                        pw = {61'd0, r_bytes[63:61]};
                    else if (r_pos == 4'd15)
                        pw = r_lastlen ? {r_bytes[60:0], 3'b000} : 64'd0;
                    else
                        pw = 64'd0;
                    r_w[r_pos] <= pw;
                    r_pos <= r_pos + 4'd1;
                    if (r_pos == 4'd15) begin
                        r_state <= S_CMP; r_rnd <= 7'd0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                S_CMP: begin
                    if (rnd >= 7'd16) r_w[rnd[3:0]] <= wt;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd <= rnd + 7'd1;
                    if (rnd == 7'(ROUNDS - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_rnd <= 7'd0;
                    r_pos <= 4'd0;
                    // once the last word is taken, a block without the length is followed by another pad block
                    if (!r_padding) r_state <= S_IN;
                    else if (r_lenblk && r_lastlen) begin
                        r_state <= S_OUT; r_oidx <= 3'd0;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT: if (!i_stall) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_state <= S_IN; r_padding <= 1'b0; r_bytes <= 64'd0;
                        r_pos <= 4'd0;
                        for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    // set when the length words go into the block being filled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lastlen <= 1'b0;
        else if (r_state == S_PAD && r_lenblk && r_pos == 4'd14) r_lastlen <= 1'b1;
        else if (r_state == S_IN) r_lastlen <= 1'b0;
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(r_oidx)) else $error("digest moved");
    a_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IN) |-> !o_pop) else $error("pop while busy");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> r_rnd < 7'(ROUNDS)) else $error("round overrun");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/sha512_hash.sv =====
`default_nettype none
// Streaming SHA-512 engine.
// Input channel: i_valid/o_stall carry one 64-bit message word per
// transaction, first byte in bits 63..56, with i_valid_bytes (0..8, counted
// only on the last word), i_message_start (restart with initial hash values)
// and i_message_end (padding and digest follow).
// Output channel: o_valid/i_stall carry the eight digest words, index 0
// first, o_last_word on index 7.
// A two-entry queue decouples the front from the compression engine.
// The engine takes in the words of a block one by one; every 16th word is
// followed by the rounds and the final addition, and no word is taken while
// they run, so the sustained rate is set by the single shared round unit.
// After the last word, padding and the length fill out the message, and one
// or two blocks are compressed before the first digest word; then one word
// per cycle while not stalled. While the receiver stalls the current digest word holds and the
// engine waits; the front still fills the queue. Reset loads the initial hash
// values, clears the byte count and empties the queue.
module sha512_hash
    import sha512_pkg::*;
#(
    parameter int ROUNDS = 80
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_valid_bytes,
    input  wire logic        i_message_start,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    t_item in_item, q_item;
    logic  q_full, q_valid, q_pop;

    assign in_item = '{word: i_data_word, start: i_message_start,
                       last: i_message_end, nbytes: i_valid_bytes};
    assign o_stall = q_full;

    sha512_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && !q_full), .i_item(in_item), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_item(q_item)
    );

    sha512_core #(.ROUNDS(ROUNDS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_item(q_item), .o_pop(q_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );
endmodule
`default_nettype wire
